// ----- rtl/closest_point_on_triangle_top_defines.svh -----
// Assertion macros for the closest point on triangle block.
`ifndef CLOSEST_POINT_ON_TRIANGLE_TOP_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("closest point check failed");
`define CPT_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("closest point reset check failed");
`else
`define CPT_ASSERT(lbl, prop)
`define CPT_ASSERT_ANY(lbl, prop)
`endif
`endif

// ----- rtl/cpt_pkg.sv -----
// Shared constants and region codes for the closest point on triangle block.
package cpt_pkg;
  localparam int CPT_COORD_BITS = 24;
  localparam int CPT_WEIGHT_FRAC_BITS = 16;
  localparam int REGION_W = 3;
  localparam logic [REGION_W-1:0] RGN_A     = 3'd0;
  localparam logic [REGION_W-1:0] RGN_B     = 3'd1;
  localparam logic [REGION_W-1:0] RGN_AB    = 3'd2;
  localparam logic [REGION_W-1:0] RGN_C     = 3'd3;
  localparam logic [REGION_W-1:0] RGN_AC    = 3'd4;
  localparam logic [REGION_W-1:0] RGN_BC    = 3'd5;
  localparam logic [REGION_W-1:0] RGN_FACE  = 3'd6;
  localparam logic [REGION_W-1:0] RGN_DEGEN = 3'd7;
endpackage

// ----- rtl/cpt_dot.sv -----
// Two stage pipelined three term dot product.
module cpt_dot import cpt_pkg::*; #(
  parameter int EW = CPT_COORD_BITS + 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [EW-1:0]   u0,
  input  logic signed [EW-1:0]   u1,
  input  logic signed [EW-1:0]   u2,
  input  logic signed [EW-1:0]   v0,
  input  logic signed [EW-1:0]   v1,
  input  logic signed [EW-1:0]   v2,
  output logic signed [2*EW+1:0] d
);
  localparam int PW = 2 * EW;
  localparam int DW = 2 * EW + 2;

  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic signed [DW-1:0] d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= PW'(u0) * PW'(v0);
      p1_r <= PW'(u1) * PW'(v1);
      p2_r <= PW'(u2) * PW'(v2);
      d_r  <= DW'(p0_r) + DW'(p1_r) + DW'(p2_r);
    end
  end

  assign d = d_r;
endmodule

// ----- rtl/cpt_wmul.sv -----
// Two stage signed multiplier built from four half width partial products.
module cpt_wmul import cpt_pkg::*; #(
  parameter int AW = 4 * CPT_COORD_BITS + 8
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a,
  input  logic signed [AW-1:0]  b,
  output logic signed [2*AW-1:0] p
);
  localparam int L  = AW / 2;
  localparam int H  = AW - L;
  localparam int PW = 2 * AW;

  logic signed [H-1:0]   ah, bh;
  logic        [L-1:0]   al, bl;
  logic signed [2*H-1:0] hh_r;
  logic signed [H+L:0]   hl_r, lh_r;
  logic        [2*L-1:0] ll_r;
  logic signed [PW-1:0]  p_r;

  assign ah = a[AW-1:L];
  assign bh = b[AW-1:L];
  assign al = a[L-1:0];
  assign bl = b[L-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= (H+L+1)'(ah) * (H+L+1)'($signed({1'b0, bl}));
      lh_r <= (H+L+1)'(bh) * (H+L+1)'($signed({1'b0, al}));
      ll_r <= al * bl;
      p_r  <= (PW'(hh_r) <<< (2 * L)) + ((PW'(hl_r) + PW'(lh_r)) <<< L)
              + PW'({1'b0, ll_r});
    end
  end

  assign p = p_r;
endmodule

// ----- rtl/cpt_div.sv -----
// Pipelined restoring divider giving a clamped unsigned fraction weight.
module cpt_div import cpt_pkg::*; #(
  parameter int NW = 8 * CPT_COORD_BITS + 19,
  parameter int F  = CPT_WEIGHT_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic        [F:0]    w
);
  localparam int MW = NW + 1;

  logic signed [MW-1:0] nx, dx;
  logic        [MW-1:0] p1_num_r, p1_den_r;
  logic                 p1_nul_r;
  logic                 sn, sd, nul_nxt;
  logic        [MW-1:0] rem_r  [0:F];
  logic        [MW-1:0] den_r  [0:F];
  logic        [F-1:0]  q_r    [0:F];
  logic                 nul_r  [0:F];
  logic                 full_r [0:F];

  assign sn = num[NW-1];
  assign sd = den[NW-1];
  assign nx = MW'(num);
  assign dx = MW'(den);
  assign nul_nxt = (num == '0) || (den == '0) || (sn != sd);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_num_r  <= sn ? -nx : nx;
      p1_den_r  <= sn ? -dx : dx;
      p1_nul_r  <= nul_nxt;
      rem_r[0]  <= p1_num_r;
      den_r[0]  <= p1_den_r;
      q_r[0]    <= '0;
      nul_r[0]  <= p1_nul_r;
      full_r[0] <= p1_den_r <= p1_num_r;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_step
    logic [MW:0] sh;
    logic        ge;
    assign sh = {rem_r[k-1], 1'b0};
    assign ge = sh >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? MW'(sh - {1'b0, den_r[k-1]}) : sh[MW-1:0];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][F-2:0], ge};
        nul_r[k]  <= nul_r[k-1];
        full_r[k] <= full_r[k-1];
      end
    end
  end

  assign w = nul_r[F] ? '0 : (full_r[F] ? ((F+1)'(1) << F) : {1'b0, q_r[F]});
endmodule

// ----- rtl/closest_point_on_triangle_top.sv -----
// Top level of the pipelined closest point on triangle block.
// The input channel carries one item per query: the point P and the vertices
// A, B and C, twelve signed Q12.12 coordinates packed in in_tdata. The output
// channel returns the closest point of the triangle in out_tdata and the
// Voronoi region code in out_tuser.
// Every item passes through every stage from acceptance to the output
// register; the restoring divider, one quotient bit per stage, makes up most
// of the pipeline depth.
// One item is accepted per cycle and one result delivered per cycle while no stall holds the pipeline.
// The whole pipeline advances together: when the output register holds a
// result that is not taken, every stage holds and in_tready falls, so no item
// is lost or repeated. Bubbles in the pipeline move on while the output
// register is empty.
// Reset clears all stage valid bits; payload registers keep whatever they had.
`include "closest_point_on_triangle_top_defines.svh"
module closest_point_on_triangle_top import cpt_pkg::*; #(
  parameter int COORD_BITS = CPT_COORD_BITS,
  parameter int WEIGHT_FRAC_BITS = CPT_WEIGHT_FRAC_BITS,
  localparam int IN_W = ((12 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // query_x, query_y, query_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
  input  logic [IN_W-1:0]     in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // near_x, near_y, near_z
  output logic [OUT_W-1:0]    out_tdata,
  // region
  output logic [REGION_W-1:0] out_tuser
);
  localparam int W    = COORD_BITS;
  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int EW   = W + 1;
  localparam int DOTW = 2 * EW + 2;
  localparam int VW   = 2 * DOTW + 1;
  localparam int NW   = 2 * DOTW + 3;
  localparam int PRW  = EW + F + 2;
  localparam int SW   = W + 3;
  localparam int N    = F + 12;
  localparam int S8   = 7;
  localparam int SE1  = F + 9;

  typedef struct packed {
    logic signed [W-1:0]  a;
    logic signed [W-1:0]  b;
    logic signed [W-1:0]  c;
    logic signed [EW-1:0] ab;
    logic signed [EW-1:0] ac;
    logic signed [EW-1:0] bc;
  } geo_t;

  typedef struct packed {
    logic signed [W-1:0]  base;
    logic signed [EW-1:0] e1;
    logic signed [EW-1:0] e2;
    logic [REGION_W-1:0]  region;
  } sel_t;

  logic                 en;
  logic [N-1:0]         vld_r;
  logic signed [W-1:0]  px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
  geo_t                 geo_nxt;
  geo_t                 geo_r [1:7];
  logic signed [EW-1:0] ap_r [0:2];
  logic signed [EW-1:0] bp_r [0:2];
  logic signed [EW-1:0] cp_r [0:2];
  logic signed [DOTW-1:0] dv [0:5];
  logic signed [DOTW-1:0] dq4_r [0:5];
  logic signed [DOTW-1:0] dq5_r [0:5];
  logic signed [2*DOTW-1:0] m14, m32, m52, m16, m36, m54;

  logic signed [VW-1:0]     s6_va_r, s6_vb_r, s6_vc_r, s7_va_r, s7_vb_r, s7_vc_r;
  logic signed [DOTW:0]     s6_n_r, s6_m_r, s6_e1d_r, s6_e2d_r;
  logic signed [DOTW:0]     s7_n_r, s7_m_r, s7_e1d_r, s7_e2d_r;
  logic signed [DOTW-1:0]   s6_d1_r, s6_d2_r, s6_d3_r, s6_d6_r;
  logic signed [DOTW-1:0]   s7_d1_r, s7_d2_r, s7_d3_r, s7_d6_r;
  logic signed [DOTW+1:0]   s7_nm_r;
  logic signed [NW-1:0]     s7_den_r;

  sel_t                 sel_nxt;
  sel_t                 sel_r [0:F+2];
  logic signed [NW-1:0] num1_nxt, den1_nxt, num2_nxt, den2_nxt;
  logic signed [NW-1:0] num1_r, den1_r, num2_r, den2_r;
  logic [F:0]           w1, w2;

  logic signed [PRW-1:0] p1_r, p2_r;
  logic signed [W-1:0]   e1_base_r;
  logic [REGION_W-1:0]   e1_region_r;
  logic signed [SW-1:0]  sum;
  logic signed [W-1:0]   sat;
  logic signed [W-1:0]   nx_r, ny_r, nz_r;
  logic [REGION_W-1:0]   nreg_r;
  logic signed [PRW-1:0] p1_nxt, p2_nxt;
  logic signed [W-1:0]   near_nxt [0:2];

  logic d1_le0, d1_ge0, d2_le0, d2_ge0, d3_le0, d3_ge0, d6_le0, d6_ge0;
  logic n_le0, n_ge0, m_le0, m_ge0, va_le0, vb_le0, vc_le0;

  assign en = !vld_r[N-1] || out_tready;
  assign in_tready = en;

  assign px = in_tdata[0*W +: W];
  assign py = in_tdata[1*W +: W];
  assign pz = in_tdata[2*W +: W];
  assign ax = in_tdata[3*W +: W];
  assign ay = in_tdata[4*W +: W];
  assign az = in_tdata[5*W +: W];
  assign bx = in_tdata[6*W +: W];
  assign by = in_tdata[7*W +: W];
  assign bz = in_tdata[8*W +: W];
  assign cx = in_tdata[9*W +: W];
  assign cy = in_tdata[10*W +: W];
  assign cz = in_tdata[11*W +: W];

  always_comb begin
    geo_nxt.a  = ax;
    geo_nxt.b  = bx;
    geo_nxt.c  = cx;
    geo_nxt.ab = EW'(bx) - EW'(ax);
    geo_nxt.ac = EW'(cx) - EW'(ax);
    geo_nxt.bc = EW'(cx) - EW'(bx);
  end

  // Only x is carried in geo_t; y and z travel in the lane copies below.
  geo_t geo_y_nxt, geo_z_nxt;
  geo_t geo_y_r [1:7];
  geo_t geo_z_r [1:7];

  always_comb begin
    geo_y_nxt.a  = ay;
    geo_y_nxt.b  = by;
    geo_y_nxt.c  = cy;
    geo_y_nxt.ab = EW'(by) - EW'(ay);
    geo_y_nxt.ac = EW'(cy) - EW'(ay);
    geo_y_nxt.bc = EW'(cy) - EW'(by);
    geo_z_nxt.a  = az;
    geo_z_nxt.b  = bz;
    geo_z_nxt.c  = cz;
    geo_z_nxt.ab = EW'(bz) - EW'(az);
    geo_z_nxt.ac = EW'(cz) - EW'(az);
    geo_z_nxt.bc = EW'(cz) - EW'(bz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[1]   <= geo_nxt;
      geo_y_r[1] <= geo_y_nxt;
      geo_z_r[1] <= geo_z_nxt;
      for (int k = 2; k <= 7; k++) begin
        geo_r[k]   <= geo_r[k-1];
        geo_y_r[k] <= geo_y_r[k-1];
        geo_z_r[k] <= geo_z_r[k-1];
      end
      ap_r[0] <= EW'(px) - EW'(ax);
      ap_r[1] <= EW'(py) - EW'(ay);
      ap_r[2] <= EW'(pz) - EW'(az);
      bp_r[0] <= EW'(px) - EW'(bx);
      bp_r[1] <= EW'(py) - EW'(by);
      bp_r[2] <= EW'(pz) - EW'(bz);
      cp_r[0] <= EW'(px) - EW'(cx);
      cp_r[1] <= EW'(py) - EW'(cy);
      cp_r[2] <= EW'(pz) - EW'(cz);
    end
  end

  cpt_dot #(.EW(EW)) u_d1 (.clk(clk), .en(en),
    .u0(geo_r[1].ab), .u1(geo_y_r[1].ab), .u2(geo_z_r[1].ab),
    .v0(ap_r[0]), .v1(ap_r[1]), .v2(ap_r[2]), .d(dv[0]));
  cpt_dot #(.EW(EW)) u_d2 (.clk(clk), .en(en),
    .u0(geo_r[1].ac), .u1(geo_y_r[1].ac), .u2(geo_z_r[1].ac),
    .v0(ap_r[0]), .v1(ap_r[1]), .v2(ap_r[2]), .d(dv[1]));
  cpt_dot #(.EW(EW)) u_d3 (.clk(clk), .en(en),
    .u0(geo_r[1].ab), .u1(geo_y_r[1].ab), .u2(geo_z_r[1].ab),
    .v0(bp_r[0]), .v1(bp_r[1]), .v2(bp_r[2]), .d(dv[2]));
  cpt_dot #(.EW(EW)) u_d4 (.clk(clk), .en(en),
    .u0(geo_r[1].ac), .u1(geo_y_r[1].ac), .u2(geo_z_r[1].ac),
    .v0(bp_r[0]), .v1(bp_r[1]), .v2(bp_r[2]), .d(dv[3]));
  cpt_dot #(.EW(EW)) u_d5 (.clk(clk), .en(en),
    .u0(geo_r[1].ab), .u1(geo_y_r[1].ab), .u2(geo_z_r[1].ab),
    .v0(cp_r[0]), .v1(cp_r[1]), .v2(cp_r[2]), .d(dv[4]));
  cpt_dot #(.EW(EW)) u_d6 (.clk(clk), .en(en),
    .u0(geo_r[1].ac), .u1(geo_y_r[1].ac), .u2(geo_z_r[1].ac),
    .v0(cp_r[0]), .v1(cp_r[1]), .v2(cp_r[2]), .d(dv[5]));

  cpt_wmul #(.AW(DOTW)) u_m14 (.clk(clk), .en(en), .a(dv[0]), .b(dv[3]), .p(m14));
  cpt_wmul #(.AW(DOTW)) u_m32 (.clk(clk), .en(en), .a(dv[2]), .b(dv[1]), .p(m32));
  cpt_wmul #(.AW(DOTW)) u_m52 (.clk(clk), .en(en), .a(dv[4]), .b(dv[1]), .p(m52));
  cpt_wmul #(.AW(DOTW)) u_m16 (.clk(clk), .en(en), .a(dv[0]), .b(dv[5]), .p(m16));
  cpt_wmul #(.AW(DOTW)) u_m36 (.clk(clk), .en(en), .a(dv[2]), .b(dv[5]), .p(m36));
  cpt_wmul #(.AW(DOTW)) u_m54 (.clk(clk), .en(en), .a(dv[4]), .b(dv[3]), .p(m54));

  always_ff @(posedge clk) begin
    if (en) begin
      dq4_r <= dv;
      dq5_r <= dq4_r;
      s6_vc_r  <= VW'(m14) - VW'(m32);
      s6_vb_r  <= VW'(m52) - VW'(m16);
      s6_va_r  <= VW'(m36) - VW'(m54);
      s6_n_r   <= (DOTW+1)'(dq5_r[3]) - (DOTW+1)'(dq5_r[2]);
      s6_m_r   <= (DOTW+1)'(dq5_r[4]) - (DOTW+1)'(dq5_r[5]);
      s6_e1d_r <= (DOTW+1)'(dq5_r[0]) - (DOTW+1)'(dq5_r[2]);
      s6_e2d_r <= (DOTW+1)'(dq5_r[1]) - (DOTW+1)'(dq5_r[5]);
      s6_d1_r  <= dq5_r[0];
      s6_d2_r  <= dq5_r[1];
      s6_d3_r  <= dq5_r[2];
      s6_d6_r  <= dq5_r[5];
      s7_den_r <= NW'(s6_va_r) + NW'(s6_vb_r) + NW'(s6_vc_r);
      s7_nm_r  <= (DOTW+2)'(s6_n_r) + (DOTW+2)'(s6_m_r);
      s7_va_r  <= s6_va_r;
      s7_vb_r  <= s6_vb_r;
      s7_vc_r  <= s6_vc_r;
      s7_n_r   <= s6_n_r;
      s7_m_r   <= s6_m_r;
      s7_e1d_r <= s6_e1d_r;
      s7_e2d_r <= s6_e2d_r;
      s7_d1_r  <= s6_d1_r;
      s7_d2_r  <= s6_d2_r;
      s7_d3_r  <= s6_d3_r;
      s7_d6_r  <= s6_d6_r;
    end
  end

  assign d1_ge0 = !s7_d1_r[DOTW-1];
  assign d1_le0 = s7_d1_r[DOTW-1] || (s7_d1_r == '0);
  assign d2_ge0 = !s7_d2_r[DOTW-1];
  assign d2_le0 = s7_d2_r[DOTW-1] || (s7_d2_r == '0);
  assign d3_ge0 = !s7_d3_r[DOTW-1];
  assign d3_le0 = s7_d3_r[DOTW-1] || (s7_d3_r == '0);
  assign d6_ge0 = !s7_d6_r[DOTW-1];
  assign d6_le0 = s7_d6_r[DOTW-1] || (s7_d6_r == '0);
  assign n_ge0  = !s7_n_r[DOTW];
  assign n_le0  = s7_n_r[DOTW] || (s7_n_r == '0);
  assign m_ge0  = !s7_m_r[DOTW];
  assign m_le0  = s7_m_r[DOTW] || (s7_m_r == '0);
  assign va_le0 = s7_va_r[VW-1] || (s7_va_r == '0);
  assign vb_le0 = s7_vb_r[VW-1] || (s7_vb_r == '0);
  assign vc_le0 = s7_vc_r[VW-1] || (s7_vc_r == '0);

  // The region tests run in priority order; regions without a weight divide zero.
  always_comb begin
    sel_nxt.base   = geo_r[7].a;
    sel_nxt.e1     = geo_r[7].ab;
    sel_nxt.e2     = geo_r[7].ac;
    sel_nxt.region = RGN_DEGEN;
    num1_nxt = '0;
    den1_nxt = '0;
    num2_nxt = '0;
    den2_nxt = '0;
    if (d1_le0 && d2_le0) begin
      sel_nxt.region = RGN_A;
    end else if (d3_ge0 && n_le0) begin
      sel_nxt.base   = geo_r[7].b;
      sel_nxt.region = RGN_B;
    end else if (vc_le0 && d1_ge0 && d3_le0) begin
      sel_nxt.region = RGN_AB;
      num1_nxt = NW'(s7_d1_r);
      den1_nxt = NW'(s7_e1d_r);
    end else if (d6_ge0 && m_le0) begin
      sel_nxt.base   = geo_r[7].c;
      sel_nxt.region = RGN_C;
    end else if (vb_le0 && d2_ge0 && d6_le0) begin
      sel_nxt.e1     = geo_r[7].ac;
      sel_nxt.e2     = geo_r[7].ab;
      sel_nxt.region = RGN_AC;
      num1_nxt = NW'(s7_d2_r);
      den1_nxt = NW'(s7_e2d_r);
    end else if (va_le0 && n_ge0 && m_ge0) begin
      sel_nxt.base   = geo_r[7].b;
      sel_nxt.e1     = geo_r[7].bc;
      sel_nxt.e2     = geo_r[7].ab;
      sel_nxt.region = RGN_BC;
      num1_nxt = NW'(s7_n_r);
      den1_nxt = NW'(s7_nm_r);
    end else if (s7_den_r != '0) begin
      sel_nxt.region = RGN_FACE;
      num1_nxt = NW'(s7_vb_r);
      den1_nxt = s7_den_r;
      num2_nxt = NW'(s7_vc_r);
      den2_nxt = s7_den_r;
    end
  end

  // The y and z lanes follow the same selection as x.
  sel_t sel_y_nxt, sel_z_nxt;
  sel_t sel_y_r [0:F+2];
  sel_t sel_z_r [0:F+2];

  always_comb begin
    sel_y_nxt = sel_nxt;
    sel_z_nxt = sel_nxt;
    case (sel_nxt.region)
      RGN_B: begin
        sel_y_nxt.base = geo_y_r[7].b;
        sel_z_nxt.base = geo_z_r[7].b;
      end
      RGN_C: begin
        sel_y_nxt.base = geo_y_r[7].c;
        sel_z_nxt.base = geo_z_r[7].c;
      end
      RGN_BC: begin
        sel_y_nxt.base = geo_y_r[7].b;
        sel_z_nxt.base = geo_z_r[7].b;
      end
      default: begin
        sel_y_nxt.base = geo_y_r[7].a;
        sel_z_nxt.base = geo_z_r[7].a;
      end
    endcase
    case (sel_nxt.region)
      RGN_AC: begin
        sel_y_nxt.e1 = geo_y_r[7].ac;
        sel_y_nxt.e2 = geo_y_r[7].ab;
        sel_z_nxt.e1 = geo_z_r[7].ac;
        sel_z_nxt.e2 = geo_z_r[7].ab;
      end
      RGN_BC: begin
        sel_y_nxt.e1 = geo_y_r[7].bc;
        sel_y_nxt.e2 = geo_y_r[7].ab;
        sel_z_nxt.e1 = geo_z_r[7].bc;
        sel_z_nxt.e2 = geo_z_r[7].ab;
      end
      default: begin
        sel_y_nxt.e1 = geo_y_r[7].ab;
        sel_y_nxt.e2 = geo_y_r[7].ac;
        sel_z_nxt.e1 = geo_z_r[7].ab;
        sel_z_nxt.e2 = geo_z_r[7].ac;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r[0]   <= sel_nxt;
      sel_y_r[0] <= sel_y_nxt;
      sel_z_r[0] <= sel_z_nxt;
      for (int k = 1; k <= F + 2; k++) begin
        sel_r[k]   <= sel_r[k-1];
        sel_y_r[k] <= sel_y_r[k-1];
        sel_z_r[k] <= sel_z_r[k-1];
      end
      num1_r <= num1_nxt;
      den1_r <= den1_nxt;
      num2_r <= num2_nxt;
      den2_r <= den2_nxt;
    end
  end

  cpt_div #(.NW(NW), .F(F)) u_div1 (.clk(clk), .en(en),
    .num(num1_r), .den(den1_r), .w(w1));
  cpt_div #(.NW(NW), .F(F)) u_div2 (.clk(clk), .en(en),
    .num(num2_r), .den(den2_r), .w(w2));

  // Three lanes of weighted edge products, then add and saturate.
  logic signed [PRW-1:0] p1y_r, p2y_r, p1z_r, p2z_r;
  logic signed [W-1:0]   e1_base_y_r, e1_base_z_r;

  function automatic logic signed [W-1:0] cpt_sum(
    input logic signed [W-1:0]   base,
    input logic signed [PRW-1:0] q1,
    input logic signed [PRW-1:0] q2
  );
    logic signed [SW-1:0] s;
    s = SW'(base) + $signed(q1[F +: SW]) + $signed(q2[F +: SW]);
    if (s[SW-1:W-1] != {(SW-W+1){s[SW-1]}}) begin
      cpt_sum = s[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      cpt_sum = s[W-1:0];
    end
  endfunction

  assign p1_nxt = PRW'(sel_r[F+2].e1) * PRW'($signed({1'b0, w1}));
  assign p2_nxt = PRW'(sel_r[F+2].e2) * PRW'($signed({1'b0, w2}));
  assign sum = SW'(e1_base_r) + $signed(p1_r[F +: SW]) + $signed(p2_r[F +: SW]);
  assign sat = (sum[SW-1:W-1] != {(SW-W+1){sum[SW-1]}})
             ? (sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
             : sum[W-1:0];
  assign near_nxt[0] = sat;
  assign near_nxt[1] = cpt_sum(e1_base_y_r, p1y_r, p2y_r);
  assign near_nxt[2] = cpt_sum(e1_base_z_r, p1z_r, p2z_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      p1y_r       <= PRW'(sel_y_r[F+2].e1) * PRW'($signed({1'b0, w1}));
      p2y_r       <= PRW'(sel_y_r[F+2].e2) * PRW'($signed({1'b0, w2}));
      p1z_r       <= PRW'(sel_z_r[F+2].e1) * PRW'($signed({1'b0, w1}));
      p2z_r       <= PRW'(sel_z_r[F+2].e2) * PRW'($signed({1'b0, w2}));
      e1_base_r   <= sel_r[F+2].base;
      e1_base_y_r <= sel_y_r[F+2].base;
      e1_base_z_r <= sel_z_r[F+2].base;
      e1_region_r <= sel_r[F+2].region;
      nx_r        <= near_nxt[0];
      ny_r        <= near_nxt[1];
      nz_r        <= near_nxt[2];
      nreg_r      <= e1_region_r;
    end
  end

  assign out_tvalid = vld_r[N-1];
  assign out_tdata  = OUT_W'({nz_r, ny_r, nx_r});
  assign out_tuser  = nreg_r;

  `CPT_ASSERT(a_w1_range, vld_r[SE1] |-> (w1 <= ((F+1)'(1) << F)))
  `CPT_ASSERT(a_w1_zero, (vld_r[SE1] && (sel_r[F+2].region == RGN_A ||
    sel_r[F+2].region == RGN_B || sel_r[F+2].region == RGN_C ||
    sel_r[F+2].region == RGN_DEGEN)) |-> (w1 == '0))
  `CPT_ASSERT(a_w2_face, (vld_r[SE1] && sel_r[F+2].region != RGN_FACE) |-> (w2 == '0))
  `CPT_ASSERT(a_stall_hold, (!en && vld_r[S8]) |=> $stable(vld_r))
  `CPT_ASSERT_ANY(a_reset_empty, !rst_n |=> !out_tvalid)
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the closest point on triangle block with random stalls.
`timescale 1ns / 100ps
module tb_top;
  import cpt_pkg::*;

  localparam int CB = CPT_COORD_BITS;
  localparam int WF = CPT_WEIGHT_FRAC_BITS;
  localparam int IN_W = ((12 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((3 * CB + 7) / 8) * 8;
  localparam int N_RANDOM = 1230;
  localparam int CYCLE_LIMIT = 300000;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;

  typedef logic signed [191:0] wide_t;
  typedef struct {
    logic signed [CB-1:0] x, y, z;
    logic [REGION_W-1:0]  rgn;
  } near_t;
  typedef struct {
    logic [IN_W-1:0] data;
    bit              typed;
    near_t           want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic [REGION_W-1:0] out_tuser;

  near_t pending[$];
  row_t  rows[$];
  int errors = 0;
  int results = 0;
  int results_seen = 0;
  int hold_cnt = 0;
  int cycles = 0;

  closest_point_on_triangle_top dut (.*);

  always #6 clk = ~clk;

  function automatic logic [IN_W-1:0] mk(longint px, longint py, longint pz,
                                         longint ax, longint ay, longint az,
                                         longint bx, longint by, longint bz,
                                         longint cx, longint cy, longint cz);
    logic [IN_W-1:0] v;
    v = '0;
    v[0*CB +: CB] = CB'(px); v[1*CB +: CB] = CB'(py); v[2*CB +: CB] = CB'(pz);
    v[3*CB +: CB] = CB'(ax); v[4*CB +: CB] = CB'(ay); v[5*CB +: CB] = CB'(az);
    v[6*CB +: CB] = CB'(bx); v[7*CB +: CB] = CB'(by); v[8*CB +: CB] = CB'(bz);
    v[9*CB +: CB] = CB'(cx); v[10*CB +: CB] = CB'(cy); v[11*CB +: CB] = CB'(cz);
    return v;
  endfunction

  function automatic near_t near_of(longint x, longint y, longint z, logic [2:0] r);
    near_t n;
    n.x = CB'(x); n.y = CB'(y); n.z = CB'(z); n.rgn = r;
    return n;
  endfunction

  function automatic wide_t dot3(longint ux, longint uy, longint uz,
                                 longint vx, longint vy, longint vz);
    return wide_t'(ux) * wide_t'(vx) + wide_t'(uy) * wide_t'(vy) + wide_t'(uz) * wide_t'(vz);
  endfunction

  function automatic longint frac_weight(wide_t num, wide_t den);
    longint q;
    q = 0;
    if (num == 0 || den == 0 || (num < 0) != (den < 0)) return 0;
    if (num < 0) begin
      num = -num;
      den = -den;
    end
    if (den <= num) return longint'(1) << WF;
    for (int i = 0; i < WF; i++) begin
      num = num + num;
      q = q << 1;
      if (den <= num) begin
        num = num - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint blend(longint base, longint e1, longint w1, longint e2, longint w2);
    longint s;
    s = base + ((e1 * w1) >>> WF) + ((e2 * w2) >>> WF);
    if (s > CMAX) s = CMAX;
    if (s < CMIN) s = CMIN;
    return s;
  endfunction

  function automatic near_t closest_point(logic [IN_W-1:0] v);
    longint p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
    longint w1, w2;
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, n, m, den;
    for (int k = 0; k < 3; k++) begin
      p[k] = $signed(v[(k) * CB +: CB]);
      a[k] = $signed(v[(3 + k) * CB +: CB]);
      b[k] = $signed(v[(6 + k) * CB +: CB]);
      c[k] = $signed(v[(9 + k) * CB +: CB]);
      ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k]; bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k];
    end
    d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
    d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
    if (d1 <= 0 && d2 <= 0) return near_of(a[0], a[1], a[2], RGN_A);
    d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
    d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
    if (d3 >= 0 && d4 <= d3) return near_of(b[0], b[1], b[2], RGN_B);
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      w1 = frac_weight(d1, d1 - d3);
      return near_of(blend(a[0], ab[0], w1, 0, 0), blend(a[1], ab[1], w1, 0, 0),
                     blend(a[2], ab[2], w1, 0, 0), RGN_AB);
    end
    d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
    d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
    if (d6 >= 0 && d5 <= d6) return near_of(c[0], c[1], c[2], RGN_C);
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      w1 = frac_weight(d2, d2 - d6);
      return near_of(blend(a[0], ac[0], w1, 0, 0), blend(a[1], ac[1], w1, 0, 0),
                     blend(a[2], ac[2], w1, 0, 0), RGN_AC);
    end
    va = d3 * d6 - d5 * d4;
    n = d4 - d3;
    m = d5 - d6;
    if (va <= 0 && n >= 0 && m >= 0) begin
      w1 = frac_weight(n, n + m);
      return near_of(blend(b[0], bc[0], w1, 0, 0), blend(b[1], bc[1], w1, 0, 0),
                     blend(b[2], bc[2], w1, 0, 0), RGN_BC);
    end
    den = va + vb + vc;
    if (den == 0) return near_of(a[0], a[1], a[2], RGN_DEGEN);
    w1 = frac_weight(vb, den);
    w2 = frac_weight(vc, den);
    return near_of(blend(a[0], ab[0], w1, ac[0], w2), blend(a[1], ab[1], w1, ac[1], w2),
                   blend(a[2], ab[2], w1, ac[2], w2), RGN_FACE);
  endfunction

  function automatic longint rnd_coord(int mode);
    case (mode)
      0: return $signed(24'($urandom));
      1: return longint'($urandom_range(0, 65535)) - 32768;
      default: return longint'($urandom_range(0, 1023)) - 512;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rnd_query();
    longint q[12];
    int mode, shape, t;
    mode = $urandom_range(0, 2);
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) q[k] = rnd_coord(mode);
    if (shape == 0) begin
      t = $urandom_range(0, 4) - 2;
      for (int k = 0; k < 3; k++) q[9 + k] = q[3 + k] + t * (q[6 + k] - q[3 + k]) / 2;
      for (int k = 0; k < 12; k++) begin
        if (q[k] > CMAX) q[k] = CMAX;
        if (q[k] < CMIN) q[k] = CMIN;
      end
    end else if (shape == 1) begin
      t = 3 * $urandom_range(1, 3);
      for (int k = 0; k < 3; k++) q[t + k] = q[(t == 3 ? 6 : 3) + k];
    end else if (shape == 2) begin
      t = 3 * $urandom_range(1, 3);
      for (int k = 0; k < 3; k++) q[k] = q[t + k];
    end else if (shape == 3) begin
      for (int k = 0; k < 3; k++) begin
        q[6 + k] = q[3 + k];
        q[9 + k] = q[3 + k];
      end
    end
    return mk(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8], q[9], q[10], q[11]);
  endfunction

  task automatic add_row(logic [IN_W-1:0] d, bit typed, near_t w);
    row_t r;
    r.data = d; r.typed = typed; r.want = w;
    rows.insert(rows.size(), r);
  endtask

  task automatic send_item(logic [IN_W-1:0] d, bit typed, near_t w, int gap);
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
    pending.insert(pending.size(), typed ? w : closest_point(d));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (results != results_seen) begin
        results_seen = results;
        if (results == 300) hold_cnt = 400;
        else if (results % 200 < 150) hold_cnt = $urandom_range(0, 8);
        else hold_cnt = 0;
      end
      if (hold_cnt > 0) begin
        out_tready = 0;
        hold_cnt = hold_cnt - 1;
      end else begin
        out_tready = 1;
      end
    end
  end

  always @(posedge clk) begin
    near_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h region %0d", out_tdata, out_tuser);
      end else begin
        w = pending.pop_front();
        if (out_tdata[0 +: CB] !== w.x || out_tdata[CB +: CB] !== w.y ||
            out_tdata[2 * CB +: CB] !== w.z || out_tuser !== w.rgn) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d r%0d got %0d %0d %0d r%0d",
                     w.x, w.y, w.z, w.rgn, $signed(out_tdata[0 +: CB]),
                     $signed(out_tdata[CB +: CB]), $signed(out_tdata[2 * CB +: CB]),
                     out_tuser);
        end
      end
      results++;
    end
  end

  initial begin
    near_t none;
    int gap;
    none = near_of(0, 0, 0, RGN_A);
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, near_of(0, 0, 0, RGN_A));
    add_row(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1,
            near_of(CMAX, CMAX, CMAX, RGN_A));
    add_row(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1,
            near_of(CMIN, CMIN, CMIN, RGN_A));
    add_row(mk(8192, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1, near_of(4096, 0, 0, RGN_B));
    add_row(mk(0, 8192, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1, near_of(0, 4096, 0, RGN_C));
    add_row(mk(-100, -200, 50, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1, near_of(0, 0, 0, RGN_A));
    add_row(mk(2048, -4096, 7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, none);
    add_row(mk(-4096, 2048, 7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, none);
    add_row(mk(4096, 4096, -9, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, none);
    add_row(mk(1024, 1024, 5000, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, none);
    add_row(mk(2048, 4096, 0, 0, 0, 0, 4096, 0, 0, 8192, 0, 0), 0, none);
    add_row(mk(5, 9, 1, 7, 7, 7, 7, 7, 7, 100, 3, 3), 0, none);
    add_row(mk(5, 9, 1, 7, 7, 7, 100, 3, 3, 7, 7, 7), 0, none);
    add_row(mk(5, 9, 1, 7, 7, 7, 100, 3, 3, 100, 3, 3), 0, none);
    add_row(mk(CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX), 0,
            none);
    add_row(mk(0, 0, 0, CMIN, CMAX, 0, CMAX, CMIN, 0, CMAX, CMAX, CMIN), 0, none);
    add_row(mk(CMIN, CMIN, 0, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN), 0, none);
    add_row(mk(3, 4, 5, -8, 0, 0, 8, 0, 0, 24, 0, 0), 0, none);
    add_row(mk(0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1), 0, none);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    foreach (rows[i]) send_item(rows[i].data, rows[i].typed, rows[i].want, $urandom_range(0, 2));
    for (int i = 0; i < N_RANDOM; i++) begin
      gap = ((i / 100) % 3 == 2) ? 0 : $urandom_range(0, 8);
      if (results >= 280 && results < 320) gap = 0;
      send_item(rnd_query(), 0, none, gap);
    end
    in_tvalid = 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cpt_pkg.sv
rtl/cpt_dot.sv
rtl/cpt_wmul.sv
rtl/cpt_div.sv
rtl/closest_point_on_triangle_top.sv
tb/sv/tb_top.sv
